@@ sv/utrb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package utrb_pkg;

  // Event codes carried by the operation field of an input beat.
  typedef enum logic [1:0] {
    OP_SEND     = 2'd0,
    OP_READ     = 2'd1,
    OP_TX_EMPTY = 2'd2,
    OP_RECEIVED = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;    // an input beat is accepted this cycle
    logic finish;  // registered ring data is ready to go to the output
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;      // output register is empty or is being drained
    logic fetch_needed;  // the offered event must read a ring entry
  } status_t;

endpackage

`default_nettype wire

@@ sv/utrb_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface utrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface utrb_out_if;
  logic       valid;
  logic       ready;
  logic       line_write;
  logic [7:0] line_byte;
  logic       read_valid;
  logic [7:0] read_byte;

  modport source (output valid, output line_write, output line_byte,
                  output read_valid, output read_byte, input ready);
  modport sink   (input valid, input line_write, input line_byte,
                  input read_valid, input read_byte, output ready);
endinterface

`default_nettype wire

@@ sv/utrb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module utrb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire utrb_pkg::status_t  status,
  output utrb_pkg::cmd_t          cmd
);

  utrb_pkg::state_t state;
  utrb_pkg::state_t state_next;
  logic             take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= utrb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign take = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      utrb_pkg::ST_IDLE: begin
        if (take && status.fetch_needed) begin
          state_next = utrb_pkg::ST_FETCH;
        end
      end
      utrb_pkg::ST_FETCH: begin
        state_next = utrb_pkg::ST_IDLE;
      end
      default: begin
        state_next = utrb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.finish = 1'b0;
    case (state)
      utrb_pkg::ST_IDLE: begin
        in_ready = status.out_free;
      end
      utrb_pkg::ST_FETCH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.take = take;
  end

  // A ring fetch always completes in the very next cycle.
  a_fetch_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == utrb_pkg::ST_FETCH) |=> (state == utrb_pkg::ST_IDLE))
    else $error("fetch state held for more than one cycle");

endmodule

`default_nettype wire

@@ sv/utrb_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module utrb_dp #(
  parameter int RECEIVE_DEPTH  = 64,
  parameter int TRANSMIT_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire utrb_pkg::cmd_t    cmd,
  output utrb_pkg::status_t      status,
  input  wire logic [1:0]        operation,
  input  wire logic [7:0]        data_byte,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic                   line_write,
  output logic [7:0]             line_byte,
  output logic                   read_valid,
  output logic [7:0]             read_byte
);

  localparam int RX_AW = $clog2(RECEIVE_DEPTH);
  localparam int TX_AW = $clog2(TRANSMIT_DEPTH);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RECEIVE_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TRANSMIT_DEPTH - 1);

  logic [7:0]       rx_mem [RECEIVE_DEPTH];
  logic [7:0]       tx_mem [TRANSMIT_DEPTH];
  logic [7:0]       rx_rdata;
  logic [7:0]       tx_rdata;

  logic [RX_AW-1:0] rx_wr_idx;
  logic [RX_AW-1:0] rx_rd_idx;
  logic [TX_AW-1:0] tx_wr_idx;
  logic [TX_AW-1:0] tx_rd_idx;
  logic             tx_busy;
  logic             pend_read;

  utrb_pkg::op_t    op;
  logic             rx_nonempty;
  logic             tx_nonempty;
  logic             rx_push;
  logic             tx_push;
  logic             load_direct;
  logic             direct_write;

  assign op          = utrb_pkg::op_t'(operation);
  assign rx_nonempty = (rx_wr_idx != rx_rd_idx);
  assign tx_nonempty = (tx_wr_idx != tx_rd_idx);

  always_comb begin
    status.fetch_needed = 1'b0;
    rx_push             = 1'b0;
    tx_push             = 1'b0;
    direct_write        = 1'b0;
    case (op)
      utrb_pkg::OP_SEND: begin
        direct_write = !tx_busy;
        tx_push      = tx_busy;
      end
      utrb_pkg::OP_READ: begin
        status.fetch_needed = rx_nonempty;
      end
      utrb_pkg::OP_TX_EMPTY: begin
        status.fetch_needed = tx_nonempty;
      end
      utrb_pkg::OP_RECEIVED: begin
        rx_push = 1'b1;
      end
      default: begin
        status.fetch_needed = 1'b0;
      end
    endcase
    status.out_free = !out_valid || out_ready;
  end

  assign load_direct = cmd.take && !status.fetch_needed;

  // Ring memories: one write port, registered read at the current read index.
  always_ff @(posedge clk) begin
    if (cmd.take && rx_push) begin
      rx_mem[rx_wr_idx] <= data_byte;
    end
    rx_rdata <= rx_mem[rx_rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.take && tx_push) begin
      tx_mem[tx_wr_idx] <= data_byte;
    end
    tx_rdata <= tx_mem[tx_rd_idx];
  end

  // Indexes, busy flag and the pending fetch kind.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wr_idx <= '0;
      rx_rd_idx <= '0;
      tx_wr_idx <= '0;
      tx_rd_idx <= '0;
      tx_busy   <= 1'b0;
      pend_read <= 1'b0;
    end else if (cmd.take) begin
      pend_read <= (op == utrb_pkg::OP_READ);
      if (rx_push) begin
        rx_wr_idx <= (rx_wr_idx == RX_LAST) ? '0 : rx_wr_idx + 1'b1;
      end
      if (tx_push) begin
        tx_wr_idx <= (tx_wr_idx == TX_LAST) ? '0 : tx_wr_idx + 1'b1;
      end
      if (direct_write) begin
        tx_busy <= 1'b1;
      end
      if (op == utrb_pkg::OP_READ && rx_nonempty) begin
        rx_rd_idx <= (rx_rd_idx == RX_LAST) ? '0 : rx_rd_idx + 1'b1;
      end
      if (op == utrb_pkg::OP_TX_EMPTY) begin
        if (tx_nonempty) begin
          tx_rd_idx <= (tx_rd_idx == TX_LAST) ? '0 : tx_rd_idx + 1'b1;
        end else begin
          tx_busy <= 1'b0;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_direct || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      line_write <= direct_write;
      line_byte  <= direct_write ? data_byte : 8'h00;
      read_valid <= 1'b0;
      read_byte  <= 8'h00;
    end else if (cmd.finish) begin
      line_write <= !pend_read;
      line_byte  <= pend_read ? 8'h00 : tx_rdata;
      read_valid <= pend_read;
      read_byte  <= pend_read ? rx_rdata : 8'h00;
    end
  end

  // With the transmitter idle nothing can be left queued.
  a_idle_tx_empty: assert property (@(posedge clk) disable iff (rst)
    !tx_busy |-> (tx_wr_idx == tx_rd_idx))
    else $error("transmit ring holds data while the transmitter is idle");

  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("fetched result not presented");

  a_direct_result: assert property (@(posedge clk) disable iff (rst)
    load_direct |=> out_valid)
    else $error("direct result not presented");

endmodule

`default_nettype wire

@@ sv/uart_tx_rx_ring_buffers.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Modport  Payload                                          Beat
// -------  -------  -----------------------------------------------  -----------------
// item     sink     operation[1:0], data_byte[7:0]                   valid && ready
// result   source   line_write, line_byte[7:0], read_valid,          valid && ready
//                   read_byte[7:0]
//
// Every accepted beat yields exactly one result beat. Sends, receives and
// reads or transmitter-empty events that find their ring empty load the
// result register directly; those that find data go through the fetch state,
// as the ring memory read port registers its data before it reaches the output.
// Reset (rst, synchronous) clears the ring indexes, the busy flag and the
// controller; ring contents are not cleared and need no clearing pass.
// The result register lets a new beat be taken in the same cycle the
// previous result is drained; a stalled result holds item.ready low.

module uart_tx_rx_ring_buffers #(
  parameter int RECEIVE_DEPTH  = 64,
  parameter int TRANSMIT_DEPTH = 64
) (
  input wire logic   clk,
  input wire logic   rst,
  utrb_in_if.sink    item,
  utrb_out_if.source result
);

  utrb_pkg::cmd_t    cmd;
  utrb_pkg::status_t status;

  // The controller sequences one event at a time and decides when the
  // registered ring data is moved to the result register.
  utrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds both rings, their indexes, the transmitter busy
  // flag and the result register.
  utrb_dp #(
    .RECEIVE_DEPTH  (RECEIVE_DEPTH),
    .TRANSMIT_DEPTH (TRANSMIT_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .operation  (item.operation),
    .data_byte  (item.data_byte),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .line_write (result.line_write),
    .line_byte  (result.line_byte),
    .read_valid (result.read_valid),
    .read_byte  (result.read_byte)
  );

endmodule

`default_nettype wire
